FILE: rtl/core/gfpm_pkg.sv
`timescale 1ns / 1ps

package gfpm_pkg;

    localparam int CFG_W = 8;
    localparam logic [CFG_W-1:0] GATE_RESET = 8'd25;

    localparam int QUO_W = 30;
    localparam logic [QUO_W-1:0] US_DIVIDEND = 30'd1000000;
    localparam logic [QUO_W-1:0] NS_DIVIDEND = 30'd1000000000;
    localparam logic [QUO_W-1:0] US_THRESHOLD = 30'd1000;

    localparam logic UNIT_NS = 1'b0;
    localparam logic UNIT_US = 1'b1;

    localparam int IN_TDATA_W = 8;
    localparam int EDGE_BIT = 0;
    localparam int TICK_BIT = 1;

    typedef enum logic [2:0] {
        S_COUNT,
        S_FCONV,
        S_DIV,
        S_PCONV,
        S_LOAD
    } t_state;

    // serial unit handshake: start toward the unit, done back from it
    typedef struct packed {
        logic start;
    } t_unit_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    function automatic logic [63:0] dec_limit(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < n; k++) begin
            p = p * 64'd10;
        end
        return p - 64'd1;
    endfunction

endpackage

FILE: rtl/core/gfpm_gate.sv
`timescale 1ns / 1ps

module gfpm_gate #(
    parameter int COUNT_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [gfpm_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_accept,
    input  logic                        i_edge,
    input  logic                        i_tick,
    output logic                        o_close,
    output logic [COUNT_BITS-1:0]       o_count
);
    import gfpm_pkg::*;

    logic [CFG_W-1:0]      r_gate_ticks;
    logic [CFG_W-1:0]      r_ticks_left;
    logic [COUNT_BITS-1:0] r_edge_count;
    logic [CFG_W-1:0]      n_ticks_left;
    logic [COUNT_BITS-1:0] n_edge_count;
    logic [COUNT_BITS-1:0] w_count;

    always_comb begin
        w_count = r_edge_count;
        if (i_edge && (r_edge_count != {COUNT_BITS{1'b1}})) begin
            w_count = r_edge_count + COUNT_BITS'(1);
        end
        o_close = i_accept && i_tick && (r_ticks_left <= CFG_W'(1));
        o_count = w_count;

        n_edge_count = r_edge_count;
        n_ticks_left = r_ticks_left;
        if (o_close) begin
            n_edge_count = '0;
            n_ticks_left = r_gate_ticks;
        end else if (i_accept) begin
            n_edge_count = w_count;
            if (i_tick) begin
                n_ticks_left = r_ticks_left - CFG_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_ticks <= GATE_RESET;
            r_ticks_left <= GATE_RESET;
            r_edge_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_gate_ticks <= i_cfg_data;
            end
            r_ticks_left <= n_ticks_left;
            r_edge_count <= n_edge_count;
        end
    end

endmodule

FILE: rtl/core/gfpm_div.sv
`timescale 1ns / 1ps

module gfpm_div #(
    parameter int COUNT_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gfpm_pkg::t_unit_cmd           i_cmd,
    input  logic [gfpm_pkg::QUO_W-1:0]    i_dividend,
    input  logic [COUNT_BITS-1:0]         i_divisor,
    output gfpm_pkg::t_unit_stat          o_stat,
    output logic [gfpm_pkg::QUO_W-1:0]    o_quotient
);
    import gfpm_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_div;
    logic [QUO_W-1:0]      r_quo;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [COUNT_BITS-1:0] n_rem;
    logic [COUNT_BITS-1:0] n_div;
    logic [QUO_W-1:0]      n_quo;
    logic [CNT_W-1:0]      n_cnt;
    logic                  n_busy;
    logic                  n_done;
    logic [COUNT_BITS:0]   w_shift;
    logic [COUNT_BITS:0]   w_diff;
    logic                  w_ge;

    always_comb begin
        // one quotient bit per cycle, restoring
        w_shift = {r_rem, r_quo[QUO_W-1]};
        w_diff  = w_shift - {1'b0, r_div};
        w_ge    = !w_diff[COUNT_BITS];

        n_rem  = r_rem;
        n_div  = r_div;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_cmd.start) begin
            n_rem  = '0;
            n_div  = i_divisor;
            n_quo  = i_dividend;
            n_cnt  = CNT_W'(QUO_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[COUNT_BITS-1:0] : w_shift[COUNT_BITS-1:0];
            n_quo = {r_quo[QUO_W-2:0], w_ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

FILE: rtl/core/gfpm_bcd.sv
`timescale 1ns / 1ps

module gfpm_bcd #(
    parameter int IN_W       = 24,
    parameter int NUM_DIGITS = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gfpm_pkg::t_unit_cmd                  i_cmd,
    input  logic [IN_W-1:0]                      i_value,
    output gfpm_pkg::t_unit_stat                 o_stat,
    output logic [4*NUM_DIGITS-1:0]              o_bcd,
    output logic [$clog2(NUM_DIGITS+1)-1:0]      o_sig
);
    import gfpm_pkg::*;

    localparam int BCD_W = 4 * NUM_DIGITS;
    localparam int DIG_W = $clog2(NUM_DIGITS + 1);
    localparam int CNT_W = $clog2(IN_W + 1);

    logic [BCD_W-1:0] r_bcd;
    logic [IN_W-1:0]  r_val;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [BCD_W-1:0] n_bcd;
    logic [IN_W-1:0]  n_val;
    logic [CNT_W-1:0] n_cnt;
    logic             n_busy;
    logic             n_done;
    logic [BCD_W-1:0] w_adj;

    always_comb begin
        // add-3 on each digit, then shift in one binary bit
        for (int d = 0; d < NUM_DIGITS; d++) begin
            w_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? (r_bcd[4*d +: 4] + 4'd3)
                                                        : r_bcd[4*d +: 4];
        end

        n_bcd  = r_bcd;
        n_val  = r_val;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_cmd.start) begin
            n_bcd  = '0;
            n_val  = i_value;
            n_cnt  = CNT_W'(IN_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {w_adj[BCD_W-2:0], r_val[IN_W-1]};
            n_val = r_val << 1;
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_comb begin
        o_sig = DIG_W'(1);
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] != 4'd0) begin
                o_sig = DIG_W'(d + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_bcd <= n_bcd;
        r_val <= n_val;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_bcd       = r_bcd;

endmodule

FILE: rtl/core/gated_frequency_period_meter_unit.sv
`timescale 1ns / 1ps
// channel  | dir | payload                                         | accepted when
// s_axis   | in  | tdata: edge_req, gate_tick                      | tvalid & tready
// m_axis   | out | tdata: freq_bcd, freq_digits, freq_overflow,    | tvalid & tready
//          |     |   period_bcd, period_digits, period_valid       |
//          |     | tuser: period_unit                              |
// cfg      | in  | i_cfg_data: gate_ticks                          | i_cfg_valid & o_cfg_ready
//
// a sample that does not close a gate is taken without a stall; a closing one starts a bit-serial run
// of bcd conversion of the count, a restoring divide and bcd conversion of the period (the last
// two skipped at zero count), each conversion max(COUNT_BITS,20) bits wide
// s_axis_tready is low during the run and while its result waits for the output register
// reset: gate length 25, edge count zero, no result pending; config is always ready

module gated_frequency_period_meter_unit #(
    parameter int COUNT_BITS = 24,
    parameter int NUM_DIGITS = 7
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [gfpm_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // edge_req, gate_tick
    input  logic [gfpm_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // freq_bcd, freq_digits, freq_overflow, period_bcd, period_digits, period_valid
    output logic [8*NUM_DIGITS+2*$clog2(NUM_DIGITS+1)+2+
                  ((8-((8*NUM_DIGITS+2*$clog2(NUM_DIGITS+1)+2)%8))%8)-1:0] m_axis_tdata,
    // period_unit
    output logic [0:0]                             m_axis_tuser
);
    import gfpm_pkg::*;

    localparam int BCD_W    = 4 * NUM_DIGITS;
    localparam int DIG_W    = $clog2(NUM_DIGITS + 1);
    localparam int CONV_W   = (COUNT_BITS > 20) ? COUNT_BITS : 20;
    localparam int FIELDS_W = 2 * BCD_W + 2 * DIG_W + 2;
    localparam int TDATA_W  = FIELDS_W + ((8 - (FIELDS_W % 8)) % 8);
    localparam logic [63:0] LIMIT = dec_limit(NUM_DIGITS);

    t_state r_state, n_state;

    logic                  w_accept;
    logic                  w_close;
    logic [COUNT_BITS-1:0] w_gate_count;
    logic [63:0]           w_count_ext;
    logic [63:0]           w_quo_ext;

    t_unit_cmd  w_div_cmd, w_bcd_cmd;
    t_unit_stat w_div_stat, w_bcd_stat;
    logic [QUO_W-1:0]  w_dividend;
    logic [QUO_W-1:0]  w_quotient;
    logic [CONV_W-1:0] w_bcd_in;
    logic [BCD_W-1:0]  w_bcd_out;
    logic [DIG_W-1:0]  w_bcd_sig;

    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_fover, n_fover;
    logic [BCD_W-1:0]      r_fbcd, n_fbcd;
    logic [DIG_W-1:0]      r_fsig, n_fsig;
    logic [BCD_W-1:0]      r_pbcd, n_pbcd;
    logic [DIG_W-1:0]      r_psig, n_psig;
    logic                  r_unit, n_unit;
    logic                  r_pvalid, n_pvalid;
    logic                  r_out_valid, n_out_valid;
    logic [TDATA_W-1:0]    r_out_data, n_out_data;
    logic                  r_out_user, n_out_user;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_COUNT);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    gfpm_gate #(
        .COUNT_BITS (COUNT_BITS)
    ) u_gate (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_edge      (s_axis_tdata[EDGE_BIT]),
        .i_tick      (s_axis_tdata[TICK_BIT]),
        .o_close     (w_close),
        .o_count     (w_gate_count)
    );

    gfpm_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_div_cmd),
        .i_dividend (w_dividend),
        .i_divisor  (r_count),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    gfpm_bcd #(
        .IN_W       (CONV_W),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_bcd_cmd),
        .i_value (w_bcd_in),
        .o_stat  (w_bcd_stat),
        .o_bcd   (w_bcd_out),
        .o_sig   (w_bcd_sig)
    );

    assign w_count_ext = 64'(w_gate_count);
    assign w_quo_ext   = 64'(w_quotient);
    assign w_dividend  = (r_count < COUNT_BITS'(US_THRESHOLD)) ? US_DIVIDEND : NS_DIVIDEND;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_fover     = r_fover;
        n_fbcd      = r_fbcd;
        n_fsig      = r_fsig;
        n_pbcd      = r_pbcd;
        n_psig      = r_psig;
        n_unit      = r_unit;
        n_pvalid    = r_pvalid;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        w_div_cmd   = '0;
        w_bcd_cmd   = '0;
        w_bcd_in    = '0;

        unique case (r_state)
            S_COUNT: begin
                if (w_close) begin
                    n_count         = w_gate_count;
                    n_fover         = (w_count_ext > LIMIT);
                    w_bcd_cmd.start = 1'b1;
                    w_bcd_in        = n_fover ? LIMIT[CONV_W-1:0] : CONV_W'(w_gate_count);
                    n_state         = S_FCONV;
                end
            end
            S_FCONV: begin
                if (w_bcd_stat.done) begin
                    n_fbcd = w_bcd_out;
                    n_fsig = w_bcd_sig;
                    if (r_count == '0) begin
                        n_pbcd   = '0;
                        n_psig   = DIG_W'(1);
                        n_unit   = UNIT_NS;
                        n_pvalid = 1'b0;
                        n_state  = S_LOAD;
                    end else begin
                        n_unit          = (r_count < COUNT_BITS'(US_THRESHOLD)) ? UNIT_US
                                                                                : UNIT_NS;
                        w_div_cmd.start = 1'b1;
                        n_state         = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    w_bcd_cmd.start = 1'b1;
                    w_bcd_in        = (w_quo_ext > LIMIT) ? LIMIT[CONV_W-1:0]
                                                          : w_quo_ext[CONV_W-1:0];
                    n_state         = S_PCONV;
                end
            end
            S_PCONV: begin
                if (w_bcd_stat.done) begin
                    n_pbcd   = w_bcd_out;
                    n_psig   = w_bcd_sig;
                    n_pvalid = 1'b1;
                    n_state  = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = TDATA_W'({r_pvalid, r_psig, r_pbcd, r_fover, r_fsig, r_fbcd});
                    n_out_user  = r_unit;
                    n_state     = S_COUNT;
                end
            end
            default: begin
                n_state = S_COUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COUNT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_count    <= n_count;
        r_fover    <= n_fover;
        r_fbcd     <= n_fbcd;
        r_fsig     <= n_fsig;
        r_pbcd     <= n_pbcd;
        r_psig     <= n_psig;
        r_unit     <= n_unit;
        r_pvalid   <= n_pvalid;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_user;

endmodule

FILE: rtl/core/gfpm_checker.sv
`timescale 1ns / 1ps

module gfpm_checker #(
    parameter int NUM_DIGITS = 7,
    parameter int TDATA_W    = 64
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]         m_axis_tuser
);
    localparam int BCD_W  = 4 * NUM_DIGITS;
    localparam int DIG_W  = $clog2(NUM_DIGITS + 1);
    localparam int FD_LO  = BCD_W;
    localparam int OV_BIT = BCD_W + DIG_W;
    localparam int PB_LO  = OV_BIT + 1;
    localparam int PD_LO  = PB_LO + BCD_W;
    localparam int PV_BIT = PD_LO + DIG_W;

    logic [DIG_W-1:0] w_fdig;
    logic [DIG_W-1:0] w_pdig;
    logic [BCD_W-1:0] w_pbcd;

    assign w_fdig = m_axis_tdata[FD_LO +: DIG_W];
    assign w_pdig = m_axis_tdata[PD_LO +: DIG_W];
    assign w_pbcd = m_axis_tdata[PB_LO +: BCD_W];

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_fdig != '0) && (w_fdig <= DIG_W'(NUM_DIGITS)) &&
                          (w_pdig != '0) && (w_pdig <= DIG_W'(NUM_DIGITS)))
        else $error("digit count out of range");

    a_no_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[PV_BIT] |->
            (w_pbcd == '0) && (w_pdig == DIG_W'(1)) && !m_axis_tuser[0])
        else $error("invalid period fields not cleared");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OV_BIT] |-> (w_fdig == DIG_W'(NUM_DIGITS)))
        else $error("saturated count not shown at full width");

endmodule

bind gated_frequency_period_meter_unit gfpm_checker #(
    .NUM_DIGITS (NUM_DIGITS),
    .TDATA_W    (TDATA_W)
) u_gfpm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
